// ----- hw/rtl/flvtd_pkg.sv -----
package flvtd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SIZE_W     = 24;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned TYPE_W     = 5;
    localparam int unsigned FIDX_W     = 4;
    localparam int unsigned POS_W      = 32;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned ERR_W      = 3;
    localparam int unsigned OUT_DATA_W = 72;

    localparam logic [SIZE_W-1:0] MAX_PAYLOAD_RST = 24'hFFFFFF;

    localparam logic [BYTE_W-1:0] SIG_F = 8'h46;
    localparam logic [BYTE_W-1:0] SIG_L = 8'h4C;
    localparam logic [BYTE_W-1:0] SIG_V = 8'h56;

    localparam logic [POS_W-1:0]  FILE_HDR_LEN  = 32'd9;
    localparam logic [POS_W-1:0]  OFFSET_START  = 32'd5;
    localparam logic [FIDX_W-1:0] TAG_HDR_LAST  = 4'd10;
    localparam logic [FIDX_W-1:0] SIZE_WORD_LAST = 4'd3;
    localparam logic [TIME_W-1:0] TAG_HDR_BYTES = 32'd11;
    localparam logic [TYPE_W-1:0] TYPE_MASK     = 5'h1F;

    typedef enum logic [5:0] {
        PH_SIG     = 6'b000001,
        PH_SKIP    = 6'b000010,
        PH_PREV0   = 6'b000100,
        PH_TAGHDR  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_TRAILER = 6'b100000
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_TAG_OK  = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_SIGNATURE = 3'd1,
        ERR_PREV0     = 3'd2,
        ERR_OVERSIZE  = 3'd3,
        ERR_TRAILER   = 3'd4,
        ERR_TRUNCATED = 3'd5
    } t_err;

endpackage

// ----- hw/rtl/flv_tag_demuxer.sv -----
// FLV tag demuxer.
// Slave stream: one file byte per beat in s_axis_tdata; s_axis_tuser[0] high marks
// end of stream (no byte carried). Master stream: one result per beat; m_axis_tuser
// gives the kind (payload byte, tag complete, error), m_axis_tlast flags the final
// payload byte of a tag, m_axis_tdata carries byte, tag type, time, size and error.
// Config channel: i_cfg_data sets the largest payload size accepted; write only
// while the block is idle. o_cfg_ready is always high.
// A beat's result passes through the input register and then the result register.
// Throughput: one byte per cycle sustained while m_axis_tready stays high; the parse
// state updates in one pass of short logic between the two registers.
// Header bytes, skipped bytes and trailer bytes that produce no result are still
// accepted one at a time like every other byte.
// Reset (synchronous, active low) returns to the signature phase, clears all
// errors and sets the size limit to its maximum.
// When the receiver holds m_axis_tready low, the result register holds, one more
// beat waits in the input register, and then s_axis_tready drops.
// After an error result the block swallows all input until reset.
module flv_tag_demuxer
    import flvtd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] data_byte
    input  logic [0:0]            s_axis_tuser,  // [0] stream_end
    // master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] payload_byte, [12:8] tag_type, [44:13] tag_time,
    // [68:45] payload_size, [71:69] error_code
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [KIND_W-1:0]     m_axis_tuser,  // [1:0] kind
    output logic                  m_axis_tlast,  // last_payload
    // config write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [SIZE_W-1:0]     i_cfg_data
);

    logic [SIZE_W-1:0] r_max_payload;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;

    t_phase              r_phase,       n_phase;
    logic [POS_W-1:0]    r_byte_pos,    n_byte_pos;
    logic [POS_W-1:0]    r_hdr_off,     n_hdr_off;
    logic [FIDX_W-1:0]   r_field_idx,   n_field_idx;
    logic [TYPE_W-1:0]   r_cur_type,    n_cur_type;
    logic [SIZE_W-1:0]   r_cur_size,    n_cur_size;
    logic [TIME_W-1:0]   r_cur_time,    n_cur_time;
    logic [SIZE_W-1:0]   r_pay_left,    n_pay_left;
    logic [TIME_W-1:0]   r_trl_acc,     n_trl_acc;
    logic                r_failed,      n_failed;

    logic                r_out_valid;
    t_kind               r_out_kind;
    logic [BYTE_W-1:0]   r_out_byte;
    logic [TYPE_W-1:0]   r_out_type;
    logic [TIME_W-1:0]   r_out_time;
    logic [SIZE_W-1:0]   r_out_size;
    logic                r_out_last;
    t_err                r_out_err;

    logic                w_adv;
    logic                w_emit;
    t_kind               w_kind;
    logic [BYTE_W-1:0]   w_byte;
    logic                w_last;
    t_err                w_err;
    logic [POS_W-1:0]    w_pos_inc;
    logic [TIME_W-1:0]   w_trl_shift;
    logic [SIZE_W-1:0]   w_pay_dec;

    assign o_cfg_ready   = 1'b1;
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_payload <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tuser[0];
        end
    end

    assign w_pos_inc   = r_byte_pos + 32'd1;
    assign w_trl_shift = {r_trl_acc[TIME_W-BYTE_W-1:0], r_in_byte};
    assign w_pay_dec   = r_pay_left - 24'd1;

    always_comb begin
        n_phase     = r_phase;
        n_byte_pos  = r_byte_pos;
        n_hdr_off   = r_hdr_off;
        n_field_idx = r_field_idx;
        n_cur_type  = r_cur_type;
        n_cur_size  = r_cur_size;
        n_cur_time  = r_cur_time;
        n_pay_left  = r_pay_left;
        n_trl_acc   = r_trl_acc;
        n_failed    = r_failed;
        w_emit      = 1'b0;
        w_kind      = KIND_ERROR;
        w_byte      = '0;
        w_last      = 1'b0;
        w_err       = ERR_NONE;

        if (r_failed) begin
            // swallow everything until reset
        end else if (r_in_end) begin
            if (!(r_phase == PH_TAGHDR && r_field_idx == '0)) begin
                n_failed = 1'b1;
                w_emit   = 1'b1;
                w_err    = ERR_TRUNCATED;
            end
        end else begin
            case (r_phase)
                PH_SIG: begin
                    if ((r_byte_pos == 32'd0 && r_in_byte != SIG_F) ||
                        (r_byte_pos == 32'd1 && r_in_byte != SIG_L) ||
                        (r_byte_pos == 32'd2 && r_in_byte != SIG_V)) begin
                        n_failed = 1'b1;
                        w_emit   = 1'b1;
                        w_err    = ERR_SIGNATURE;
                    end else begin
                        if (r_byte_pos >= OFFSET_START) begin
                            n_hdr_off = {r_hdr_off[POS_W-BYTE_W-1:0], r_in_byte};
                        end
                        n_byte_pos = w_pos_inc;
                        if (w_pos_inc == FILE_HDR_LEN) begin
                            n_phase     = (n_hdr_off > FILE_HDR_LEN) ? PH_SKIP : PH_PREV0;
                            n_field_idx = '0;
                            n_trl_acc   = '0;
                        end
                    end
                end
                PH_SKIP: begin
                    n_byte_pos = w_pos_inc;
                    if (w_pos_inc >= r_hdr_off) begin
                        n_phase     = PH_PREV0;
                        n_field_idx = '0;
                        n_trl_acc   = '0;
                    end
                end
                PH_PREV0: begin
                    n_trl_acc   = w_trl_shift;
                    n_field_idx = r_field_idx + 4'd1;
                    if (r_field_idx == SIZE_WORD_LAST) begin
                        if (w_trl_shift != '0) begin
                            n_failed = 1'b1;
                            w_emit   = 1'b1;
                            w_err    = ERR_PREV0;
                        end else begin
                            n_phase     = PH_TAGHDR;
                            n_field_idx = '0;
                        end
                    end
                end
                PH_TAGHDR: begin
                    case (r_field_idx)
                        4'd0: begin
                            n_cur_type = r_in_byte[TYPE_W-1:0] & TYPE_MASK;
                            n_cur_size = '0;
                            n_cur_time = '0;
                        end
                        4'd1, 4'd2, 4'd3: begin
                            n_cur_size = {r_cur_size[SIZE_W-BYTE_W-1:0], r_in_byte};
                        end
                        4'd4, 4'd5, 4'd6: begin
                            n_cur_time = {8'd0, r_cur_time[SIZE_W-BYTE_W-1:0], r_in_byte};
                        end
                        4'd7: begin
                            n_cur_time = {r_in_byte, r_cur_time[SIZE_W-1:0]};
                        end
                        default: begin
                        end
                    endcase
                    n_field_idx = r_field_idx + 4'd1;
                    if (r_field_idx == TAG_HDR_LAST) begin
                        n_field_idx = '0;
                        n_trl_acc   = '0;
                        if (r_cur_size > r_max_payload) begin
                            n_failed = 1'b1;
                            w_emit   = 1'b1;
                            w_err    = ERR_OVERSIZE;
                        end else begin
                            n_pay_left = r_cur_size;
                            n_phase    = (r_cur_size == '0) ? PH_TRAILER : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_pay_left = w_pay_dec;
                    w_emit     = 1'b1;
                    w_kind     = KIND_PAYLOAD;
                    w_byte     = r_in_byte;
                    if (w_pay_dec == '0) begin
                        n_phase     = PH_TRAILER;
                        n_field_idx = '0;
                        n_trl_acc   = '0;
                        w_last      = 1'b1;
                    end
                end
                PH_TRAILER: begin
                    n_trl_acc   = w_trl_shift;
                    n_field_idx = r_field_idx + 4'd1;
                    if (r_field_idx == SIZE_WORD_LAST) begin
                        n_field_idx = '0;
                        n_phase     = PH_TAGHDR;
                        w_emit      = 1'b1;
                        if (w_trl_shift != ({8'd0, r_cur_size} + TAG_HDR_BYTES)) begin
                            n_failed = 1'b1;
                            w_err    = ERR_TRAILER;
                        end else begin
                            w_kind = KIND_TAG_OK;
                        end
                    end
                end
                default: begin
                    n_phase = PH_SIG;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIG;
            r_byte_pos  <= '0;
            r_hdr_off   <= '0;
            r_field_idx <= '0;
            r_cur_type  <= '0;
            r_cur_size  <= '0;
            r_cur_time  <= '0;
            r_pay_left  <= '0;
            r_trl_acc   <= '0;
            r_failed    <= 1'b0;
        end else if (w_adv) begin
            r_phase     <= n_phase;
            r_byte_pos  <= n_byte_pos;
            r_hdr_off   <= n_hdr_off;
            r_field_idx <= n_field_idx;
            r_cur_type  <= n_cur_type;
            r_cur_size  <= n_cur_size;
            r_cur_time  <= n_cur_time;
            r_pay_left  <= n_pay_left;
            r_trl_acc   <= n_trl_acc;
            r_failed    <= n_failed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_kind <= w_kind;
            r_out_byte <= w_byte;
            r_out_type <= n_cur_type;
            r_out_time <= n_cur_time;
            r_out_size <= n_cur_size;
            r_out_last <= w_last;
            r_out_err  <= w_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {r_out_err, r_out_size, r_out_time, r_out_type, r_out_byte};

`ifndef NO_ASSERTIONS
    a_failed_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_failed && !r_out_valid) |=> !r_out_valid)
        else $error("result produced after sticky error");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_ERROR) |-> (r_out_err != ERR_NONE))
        else $error("error result without error code");

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_pay_left != '0))
        else $error("payload phase with nothing left");

    a_tag_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit && w_kind == KIND_TAG_OK) |=>
            (r_phase == PH_TAGHDR && r_field_idx == '0))
        else $error("tag complete without return to header");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with free pipeline");
`endif

endmodule

// ----- test/tb_flv_tag_demuxer.sv -----
module tb_flv_tag_demuxer;
    import flvtd_pkg::*;

    localparam int STUCK_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int REPORT_CAP    = 50;

    // how the run ends: a clean stream or one kind of sticky error
    localparam int PLAN_BAD_SIG     = 0;
    localparam int PLAN_BAD_PREV    = 1;
    localparam int PLAN_EMPTY       = 2;
    localparam int PLAN_OVERSIZE    = 3;
    localparam int PLAN_BAD_TRAILER = 4;
    localparam int PLAN_TRUNCATE    = 5;
    localparam int PLAN_CLEAN       = 6;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [SIZE_W-1:0]     i_cfg_data = '0;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] pbyte;
        logic [TYPE_W-1:0] ttype;
        logic [TIME_W-1:0] stamp;
        logic [SIZE_W-1:0] size;
        logic              last;
        t_err              code;
    } t_tag_result;

    // Tracks the parse state of the stream and the results it must produce.
    class tag_ledger;
        logic [SIZE_W-1:0] max_payload;
        t_phase            stage;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  offset;
        logic [31:0]       accum;
        logic [FIDX_W-1:0] fidx;
        logic [TYPE_W-1:0] ttype;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] left;
        logic [TIME_W-1:0] stamp;
        bit                failed;
        t_tag_result       pending[$];
        int                mismatches;

        function new();
            max_payload = MAX_PAYLOAD_RST;
            stage       = PH_SIG;
            pos         = '0;
            offset      = '0;
            accum       = '0;
            fidx        = '0;
            ttype       = '0;
            size        = '0;
            left        = '0;
            stamp       = '0;
            failed      = 1'b0;
            mismatches  = 0;
        endfunction

        function void push_result(input t_kind kind, input logic [7:0] pbyte,
                                  input logic last, input t_err code);
            t_tag_result r;
            r.kind  = kind;
            r.pbyte = pbyte;
            r.ttype = ttype;
            r.stamp = stamp;
            r.size  = size;
            r.last  = last;
            r.code  = code;
            pending.push_back(r);
            if (kind == KIND_ERROR)
                failed = 1'b1;
        endfunction

        function void note_beat(input logic [7:0] b, input logic fin);
            if (failed)
                return;
            if (fin) begin
                // end of stream is only clean between tags
                if (stage != PH_TAGHDR || fidx != 0)
                    push_result(KIND_ERROR, 8'h00, 1'b0, ERR_TRUNCATED);
                return;
            end
            case (stage)
                PH_SIG: begin
                    if ((pos == 0 && b != SIG_F) || (pos == 1 && b != SIG_L) ||
                        (pos == 2 && b != SIG_V)) begin
                        push_result(KIND_ERROR, 8'h00, 1'b0, ERR_SIGNATURE);
                        return;
                    end
                    if (pos >= OFFSET_START)
                        offset = {offset[23:0], b};
                    pos++;
                    if (pos == FILE_HDR_LEN) begin
                        stage = (offset > FILE_HDR_LEN) ? PH_SKIP : PH_PREV0;
                        fidx  = '0;
                        accum = '0;
                    end
                end
                PH_SKIP: begin
                    pos++;
                    if (pos >= offset) begin
                        stage = PH_PREV0;
                        fidx  = '0;
                        accum = '0;
                    end
                end
                PH_PREV0: begin
                    accum = {accum[23:0], b};
                    fidx++;
                    if (fidx == 4) begin
                        if (accum != 0) begin
                            push_result(KIND_ERROR, 8'h00, 1'b0, ERR_PREV0);
                            return;
                        end
                        stage = PH_TAGHDR;
                        fidx  = '0;
                    end
                end
                PH_TAGHDR: begin
                    case (fidx)
                        0: begin
                            ttype = b[4:0];
                            size  = '0;
                            stamp = '0;
                        end
                        1, 2, 3: size = {size[15:0], b};
                        4, 5, 6: stamp = {8'h00, stamp[15:0], b};
                        7: stamp[31:24] = b;
                        default: ;
                    endcase
                    fidx++;
                    if (fidx == 11) begin
                        fidx  = '0;
                        accum = '0;
                        if (size > max_payload) begin
                            push_result(KIND_ERROR, 8'h00, 1'b0, ERR_OVERSIZE);
                            return;
                        end
                        left  = size;
                        stage = (size == 0) ? PH_TRAILER : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    left = left - 1'b1;
                    if (left == 0) begin
                        stage = PH_TRAILER;
                        fidx  = '0;
                        accum = '0;
                        push_result(KIND_PAYLOAD, b, 1'b1, ERR_NONE);
                    end else begin
                        push_result(KIND_PAYLOAD, b, 1'b0, ERR_NONE);
                    end
                end
                PH_TRAILER: begin
                    accum = {accum[23:0], b};
                    fidx++;
                    if (fidx == 4) begin
                        fidx  = '0;
                        stage = PH_TAGHDR;
                        if (accum != {8'h00, size} + TAG_HDR_BYTES)
                            push_result(KIND_ERROR, 8'h00, 1'b0, ERR_TRAILER);
                        else
                            push_result(KIND_TAG_OK, 8'h00, 1'b0, ERR_NONE);
                    end
                end
                default: stage = PH_SIG;
            endcase
        endfunction

        function void match_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: %s mismatch, expected %0h, got %0h",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(input logic [KIND_W-1:0] kind,
                                   input logic [OUT_DATA_W-1:0] data, input logic last);
            t_tag_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: unexpected beat, expected none, got kind %0h data %0h",
                             $time, kind, data);
                return;
            end
            want = pending.pop_front();
            match_field("kind", 32'(want.kind), 32'(kind));
            match_field("payload_byte", 32'(want.pbyte), 32'(data[7:0]));
            match_field("tag_type", 32'(want.ttype), 32'(data[12:8]));
            match_field("tag_time", want.stamp, data[44:13]);
            match_field("payload_size", 32'(want.size), 32'(data[68:45]));
            match_field("last_payload", 32'(want.last), 32'(last));
            match_field("error_code", 32'(want.code), 32'(data[71:69]));
        endfunction
    endclass

    tag_ledger ledger;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        beats_sent = 0;
    int        rx_hold_left = 0;
    bit        rx_hold_req = 1'b0;
    bit        rx_hold_done = 1'b0;
    int        stuck_cycles = 0;

    flv_tag_demuxer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: random backpressure, plus a long hold when asked
    always @(negedge i_clk) begin
        if (rx_hold_req && !rx_hold_done) begin
            rx_hold_done = 1'b1;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
            $display("flv_tag_demuxer regression: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly short payloads, now and then one right at the limit or at 300, whichever is smaller
    function automatic logic [23:0] pick_size();
        int lim;
        lim = (ledger.max_payload > 300) ? 300 : ledger.max_payload;
        case ($urandom_range(0, 9))
            0: return 24'd0;
            1: return 24'(lim);
            2, 3: return 24'($urandom_range(0, lim));
            default: return 24'($urandom_range(0, (lim > 24) ? 24 : lim));
        endcase
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic fin);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        ledger.note_beat(b, fin);
        beats_sent++;
    endtask

    // hold the sender until every pending result has arrived, then let the pipe settle
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (ledger.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [SIZE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.max_payload = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_file_header(input logic [31:0] offset, input int bad_pos,
                                    input logic [31:0] first_size);
        logic [23:0] sig;
        sig = {SIG_V, SIG_L, SIG_F};
        for (int k = 0; k < 3; k++) begin
            if (k == bad_pos)
                send_beat(sig[8*k +: 8] ^ 8'($urandom_range(1, 255)), 1'b0);
            else
                send_beat(sig[8*k +: 8], 1'b0);
        end
        send_beat(rand_byte(), 1'b0);
        send_beat(rand_byte(), 1'b0);
        for (int k = 3; k >= 0; k--)
            send_beat(offset[8*k +: 8], 1'b0);
        if (offset > FILE_HDR_LEN)
            repeat (offset - FILE_HDR_LEN) send_beat(rand_byte(), 1'b0);
        for (int k = 3; k >= 0; k--)
            send_beat(first_size[8*k +: 8], 1'b0);
    endtask

    // keep < 0 sends the whole tag, else only its first keep bytes
    task automatic send_tag(input logic [7:0] type_byte, input logic [23:0] size,
                            input logic [31:0] stamp, input int keep,
                            input logic bad_trailer);
        logic [7:0]  bytes_q[$];
        logic [31:0] trailer;
        int          total;
        total = 15 + size;
        if (keep < 0)
            keep = total;
        bytes_q.push_back(type_byte);
        bytes_q.push_back(size[23:16]);
        bytes_q.push_back(size[15:8]);
        bytes_q.push_back(size[7:0]);
        bytes_q.push_back(stamp[23:16]);
        bytes_q.push_back(stamp[15:8]);
        bytes_q.push_back(stamp[7:0]);
        bytes_q.push_back(stamp[31:24]);
        repeat (3) bytes_q.push_back(rand_byte());
        for (int i = 0; i < size && bytes_q.size() < keep; i++)
            bytes_q.push_back(rand_byte());
        trailer = {8'h00, size} + TAG_HDR_BYTES;
        if (bad_trailer)
            trailer = trailer ^ (32'h1 << $urandom_range(0, 31));
        for (int k = 3; k >= 0; k--)
            bytes_q.push_back(trailer[8*k +: 8]);
        for (int i = 0; i < keep && i < bytes_q.size(); i++)
            send_beat(bytes_q[i], 1'b0);
    endtask

    task automatic run_tags(input int target);
        logic [31:0] stamp;
        while (beats_sent < target) begin
            // an end marker between tags must pass without a result
            if ($urandom_range(0, 11) == 0)
                send_beat(rand_byte(), 1'b1);
            stamp = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
            send_tag(rand_byte(), pick_size(), stamp, -1, 1'b0);
        end
    endtask

    initial begin
        int          pick;
        int          err_plan;
        logic [31:0] offset;
        logic [31:0] first_size;
        logic [23:0] size;
        ledger = new();
        pick = $urandom_range(0, 19);
        case (pick)
            0: err_plan = PLAN_BAD_SIG;
            1: err_plan = PLAN_BAD_PREV;
            2: err_plan = PLAN_EMPTY;
            3, 4, 5: err_plan = PLAN_OVERSIZE;
            6, 7, 8: err_plan = PLAN_BAD_TRAILER;
            9, 10, 11: err_plan = PLAN_TRUNCATE;
            default: err_plan = PLAN_CLEAN;
        endcase
        case ($urandom_range(0, 3))
            0: offset = $urandom_range(0, 8);
            1: offset = FILE_HDR_LEN;
            default: offset = $urandom_range(10, 40);
        endcase
        first_size = '0;
        if (err_plan == PLAN_BAD_PREV)
            first_size = $urandom | (32'h1 << $urandom_range(0, 31));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_limit(MAX_PAYLOAD_RST);
        tx_idle_pct = 36;
        rx_idle_pct = 79;

        if (err_plan == PLAN_EMPTY)
            send_beat(rand_byte(), 1'b1);
        send_file_header(offset, (err_plan == PLAN_BAD_SIG) ? $urandom_range(0, 2) : -1,
                         first_size);
        send_beat(8'hFF, 1'b1);
        send_tag(8'hFF, 24'd0, 32'hFFFF_FFFF, -1, 1'b0);
        send_tag(8'h00, 24'd1, 32'h0000_0000, -1, 1'b0);
        send_tag(8'hE9, 24'd3, 32'h8000_0001, -1, 1'b0);
        send_beat(8'h00, 1'b1);
        run_tags(320);

        drain_results();
        write_limit(24'd0);
        tx_idle_pct = 79;
        rx_idle_pct = 36;
        run_tags(380);

        drain_results();
        write_limit(24'($urandom_range(1, 24)));
        run_tags(640);

        drain_results();
        write_limit(24'($urandom_range(25, 400)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        run_tags(930);

        drain_results();
        case (err_plan)
            PLAN_OVERSIZE: begin
                if ($urandom_range(0, 1) == 0)
                    size = ledger.max_payload + 1'b1;
                else
                    size = 24'($urandom_range(ledger.max_payload + 1, 24'hFF_FFFF));
                send_tag(rand_byte(), size, $urandom, 11, 1'b0);
            end
            PLAN_BAD_TRAILER: send_tag(rand_byte(), pick_size(), $urandom, -1, 1'b1);
            PLAN_TRUNCATE: begin
                size = pick_size();
                send_tag(rand_byte(), size, $urandom, $urandom_range(1, 14 + size), 1'b0);
                send_beat(rand_byte(), 1'b1);
            end
            default: ;
        endcase
        // trailing junk: swallowed after an error, parsed as a broken tag otherwise
        repeat (16) send_beat(rand_byte(), $urandom_range(0, 3) == 0);
        drain_results();

        if (ledger.pending.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, ledger.pending.size());
            ledger.mismatches++;
        end
        if (ledger.mismatches == 0)
            $display("flv_tag_demuxer regression: pass");
        else
            $display("flv_tag_demuxer regression: fail");
        $finish;
    end

endmodule
